/* design/lac_pkg.sv */
package lac_pkg;

	// fixed field widths
	localparam int NUM_VALUES  = 8;
	localparam int VALUE_W     = 2;
	localparam int FCOUNT_W    = 4;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int MISSING_W   = 9;

	// parameter defaults
	localparam int MAX_FACTORS_DEF = 8;
	localparam int MAX_LEVELS_DEF  = 4;
	localparam int MAX_ROWS_DEF    = 64;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACTOR_COUNT = 1'b0,
		REG_LEVEL_CODES  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_0;
		logic [VALUE_W-1:0] value_1;
		logic [VALUE_W-1:0] value_2;
		logic [VALUE_W-1:0] value_3;
		logic [VALUE_W-1:0] value_4;
		logic [VALUE_W-1:0] value_5;
		logic [VALUE_W-1:0] value_6;
		logic [VALUE_W-1:0] value_7;
		logic               last_row;
	} row_t;

	typedef struct packed {
		logic                 coverage_ok;
		logic [MISSING_W-1:0] missing_pairs;
		logic                 locating_ok;
		logic                 row_overflow;
	} report_t;

endpackage

/* design/lac_stream_if.sv */
interface lac_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* design/locating_array_checker.sv */
// strength-2 covering and locating array checker
//
// rows (sink, lac_pkg::row_t): one test array row per transaction, one level
// per factor, last_row marks the final row of the array
// report (source, lac_pkg::report_t): one transaction per array, after its
// last row: coverage flag, missing pair count, locating flag, overflow flag
// cfg_we/cfg_index/cfg_data: register write, to be issued only while idle
//
// one bitmap memory (one read and one write port) holds the pair bitmaps; a
// second memory lists the non-empty ones for the locating check. a row takes
// one read-modify-write of a bitmap per factor pair, pipelined one per cycle.
// a last row then adds a sweep over all 2^(2*FW+2*LW) bitmap addresses
// (1024 by default), reading, classifying and clearing one entry a cycle,
// then the locating check over the n non-empty pairs, comparing each pair of
// pairs for nesting and stopping at the first hit.
// rows.ready is low while any of this runs.
// after reset a clearing pass over all 1024 addresses (the memory depth)
// zeroes the bitmaps; no row is taken meanwhile, config writes are.
// a finished report sits in an output register; new rows are taken while it
// waits, and only the next report stalls until report.ready frees it
module locating_array_checker #(
	parameter int MAX_FACTORS = lac_pkg::MAX_FACTORS_DEF,
	parameter int MAX_LEVELS  = lac_pkg::MAX_LEVELS_DEF,
	parameter int MAX_ROWS    = lac_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lac_stream_if.sink                    rows,
	lac_stream_if.source                  report,
	input  logic                          cfg_we,
	input  logic [lac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lac_pkg::CFG_W-1:0]     cfg_data
);

	localparam int FW    = $clog2(MAX_FACTORS);
	localparam int LW    = $clog2(MAX_LEVELS);
	localparam int AW    = 2 * FW + 2 * LW;
	localparam int DEPTH = 2 ** AW;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int NV    = lac_pkg::NUM_VALUES;
	localparam int VW    = lac_pkg::VALUE_W;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_ROW, ST_ROW_END, ST_SWEEP, ST_SWEEP_END,
		ST_LX, ST_LP, ST_RY, ST_CY, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [lac_pkg::FCOUNT_W-1:0] fc_q;
	logic [NV-1:0][VW-1:0]        lvl_q;

	// control
	logic [FW-1:0]  i_q, j_q;
	logic [RCW-1:0] row_cnt_q;
	logic           ovf_q, rec_q, last_q;
	logic [AW-1:0]  sweep_q;
	logic           sw_valid_s1;
	logic [AW-1:0]  sw_addr_s1;
	logic [CW-1:0]  count_q, missing_q, x_q, y_q;
	logic           loc_q;
	logic           out_valid_q;
	logic           wr_pend_s1;

	// payload
	logic [NV-1:0][VW-1:0]   vals_q;
	logic [AW-1:0]           wr_addr_s1;
	logic [MAX_ROWS-1:0]     wr_bit_s1;
	logic [MAX_ROWS-1:0]     p_q;
	lac_pkg::report_t        out_q;

	// memories
	logic [MAX_ROWS-1:0] bmp_mem [DEPTH];
	logic [MAX_ROWS-1:0] act_mem [DEPTH];
	logic [MAX_ROWS-1:0] bmp_rd_q, act_rd_q;

	function automatic logic [2:0] levels_of(input logic [VW-1:0] code);
		logic [2:0] n;
		n = {1'b0, code} + 3'd1;
		return (n > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : n;
	endfunction

	logic [lac_pkg::FCOUNT_W-1:0] nf;
	assign nf = (fc_q > lac_pkg::FCOUNT_W'(MAX_FACTORS)) ?
		lac_pkg::FCOUNT_W'(MAX_FACTORS) : fc_q;

	// row step: the current factor pair and its cell
	logic [VW-1:0] vi, vj;
	logic          row_hit;
	logic [AW-1:0] row_addr;
	assign vi = vals_q[i_q];
	assign vj = vals_q[j_q];
	assign row_hit = rec_q && (lac_pkg::FCOUNT_W'(j_q) < nf) &&
		({1'b0, vi} < levels_of(lvl_q[i_q])) && ({1'b0, vj} < levels_of(lvl_q[j_q]));
	assign row_addr = {i_q, j_q, LW'(vi), LW'(vj)};

	// sweep step: is the entry just read part of the current configuration
	logic [FW-1:0] sw_i, sw_j;
	logic [LW-1:0] sw_a, sw_b;
	logic          entry_ok, entry_live;
	assign sw_i = sw_addr_s1[AW-1 -: FW];
	assign sw_j = sw_addr_s1[AW-FW-1 -: FW];
	assign sw_a = sw_addr_s1[2*LW-1 -: LW];
	assign sw_b = sw_addr_s1[LW-1:0];
	assign entry_ok = sw_valid_s1 && (sw_i < sw_j) &&
		(lac_pkg::FCOUNT_W'(sw_j) < nf) &&
		(3'(sw_a) < levels_of(lvl_q[sw_i])) && (3'(sw_b) < levels_of(lvl_q[sw_j]));
	assign entry_live = entry_ok && (bmp_rd_q != '0);

	// locating compare of two non-empty row sets
	logic nested;
	assign nested = ((p_q & act_rd_q) != '0) &&
		(((p_q & ~act_rd_q) == '0) || ((act_rd_q & ~p_q) == '0));

	logic last_pair;
	assign last_pair = (j_q == FW'(MAX_FACTORS - 1)) && (i_q == FW'(MAX_FACTORS - 2));

	assign rows.ready     = (state_q == ST_IDLE);
	assign report.valid   = out_valid_q;
	assign report.payload = out_q;

	// bitmap memory: one read and one write per cycle
	logic                bmp_we;
	logic [AW-1:0]       bmp_raddr, bmp_waddr;
	logic [MAX_ROWS-1:0] bmp_wdata;

	always_comb begin
		bmp_raddr = (state_q == ST_ROW) ? row_addr : sweep_q;
		if (wr_pend_s1) begin
			bmp_we    = 1'b1;
			bmp_waddr = wr_addr_s1;
			bmp_wdata = bmp_rd_q | wr_bit_s1;
		end else begin
			bmp_we    = (state_q == ST_INIT) || (state_q == ST_SWEEP);
			bmp_waddr = sweep_q;
			bmp_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		bmp_rd_q <= bmp_mem[bmp_raddr];
		if (bmp_we) begin
			bmp_mem[bmp_waddr] <= bmp_wdata;
		end
	end

	// list of non-empty bitmaps for the locating check
	logic [AW-1:0] act_raddr;
	assign act_raddr = (state_q == ST_RY) ? y_q[AW-1:0] : x_q[AW-1:0];

	always_ff @(posedge clk) begin
		act_rd_q <= act_mem[act_raddr];
		if (entry_live) begin
			act_mem[count_q[AW-1:0]] <= bmp_rd_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rows.valid && rows.ready) begin
			vals_q <= {rows.payload.value_7, rows.payload.value_6,
				rows.payload.value_5, rows.payload.value_4,
				rows.payload.value_3, rows.payload.value_2,
				rows.payload.value_1, rows.payload.value_0};
		end
		wr_addr_s1 <= row_addr;
		wr_bit_s1  <= MAX_ROWS'(1) << row_cnt_q;
		sw_addr_s1 <= sweep_q;
		if (state_q == ST_LP) begin
			p_q <= act_rd_q;
		end
		if (state_q == ST_DONE && (!out_valid_q || report.ready)) begin
			out_q.coverage_ok   <= (missing_q == '0);
			out_q.missing_pairs <= missing_q[lac_pkg::MISSING_W-1:0];
			out_q.locating_ok   <= loc_q;
			out_q.row_overflow  <= ovf_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			fc_q        <= lac_pkg::FCOUNT_W'(8);
			lvl_q       <= '1;
			i_q         <= '0;
			j_q         <= '0;
			row_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			rec_q       <= 1'b0;
			last_q      <= 1'b0;
			sweep_q     <= '0;
			sw_valid_s1 <= 1'b0;
			count_q     <= '0;
			missing_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			loc_q       <= 1'b1;
			out_valid_q <= 1'b0;
			wr_pend_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (lac_pkg::reg_idx_t'(cfg_index))
					lac_pkg::REG_FACTOR_COUNT: fc_q  <= cfg_data[lac_pkg::FCOUNT_W-1:0];
					lac_pkg::REG_LEVEL_CODES:  lvl_q <= cfg_data;
					default: ;
				endcase
			end
			// the done step reloads the output register itself
			if (report.valid && report.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			wr_pend_s1  <= (state_q == ST_ROW) && row_hit;
			sw_valid_s1 <= (state_q == ST_SWEEP);
			if (entry_ok) begin
				if (bmp_rd_q == '0) begin
					missing_q <= missing_q + CW'(1);
				end else begin
					count_q <= count_q + CW'(1);
				end
			end

			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (rows.valid) begin
						i_q     <= '0;
						j_q     <= FW'(1);
						rec_q   <= (row_cnt_q < RCW'(MAX_ROWS));
						last_q  <= rows.payload.last_row;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (last_pair) begin
						state_q <= ST_ROW_END;
					end else if (j_q == FW'(MAX_FACTORS - 1)) begin
						i_q <= i_q + FW'(1);
						j_q <= i_q + FW'(2);
					end else begin
						j_q <= j_q + FW'(1);
					end
				end
				ST_ROW_END: begin
					if (rec_q) begin
						row_cnt_q <= row_cnt_q + RCW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (last_q) begin
						sweep_q   <= '0;
						count_q   <= '0;
						missing_q <= '0;
						loc_q     <= 1'b1;
						state_q   <= ST_SWEEP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == '1) begin
						state_q <= ST_SWEEP_END;
					end
				end
				ST_SWEEP_END: begin
					// last entry is classified in this cycle
					x_q <= '0;
					y_q <= CW'(1);
					if ((count_q + CW'(entry_live)) < CW'(2)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_LX;
					end
				end
				ST_LX: state_q <= ST_LP;
				ST_LP: state_q <= ST_RY;
				ST_RY: state_q <= ST_CY;
				ST_CY: begin
					if (nested) begin
						loc_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if ((y_q + CW'(1)) < count_q) begin
						y_q     <= y_q + CW'(1);
						state_q <= ST_RY;
					end else if ((x_q + CW'(2)) < count_q) begin
						x_q     <= x_q + CW'(1);
						y_q     <= x_q + CW'(2);
						state_q <= ST_LX;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || report.ready) begin
						out_valid_q <= 1'b1;
						row_cnt_q   <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bitmap read-modify-write updates only trail the row walk
	a_wr_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (state_q == ST_ROW || state_q == ST_ROW_END))
		else $error("bitmap write outside row walk");

	a_row_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= RCW'(MAX_ROWS))
		else $error("row count past capacity");

	a_cov_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.coverage_ok) |-> (out_q.missing_pairs == '0))
		else $error("coverage flag disagrees with missing count");

	a_report_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("report raised outside done step");

endmodule
